FILE: hdl/ehi_pkg.sv
// ----------------------------------------------------------------------------
// ehi_pkg
// Types, constants and helpers for the extendible hash index.
// ----------------------------------------------------------------------------
package ehi_pkg;

  localparam int MaxDepth       = 10;
  localparam int BucketCapacity = 8;
  localparam int NumBuckets     = 1024;
  localparam int DirSize        = 1 << MaxDepth;
  localparam int DirW           = MaxDepth;
  localparam int BktW           = $clog2(NumBuckets);
  localparam int SlotW          = $clog2(BucketCapacity);
  localparam int FillW          = $clog2(BucketCapacity + 1);
  localparam int AddrW          = BktW + SlotW;
  localparam int DepthW         = 4;
  localparam int FreeW          = BktW + 1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_MATCH    = 2'd1,
    ST_NOMATCH  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] key;
    logic        [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic        [31:0] found_payload;
    logic               last;
  } out_item_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // latch input item
    CMD_HASH,      // compute directory index
    CMD_DIR_RD,    // issue directory read at hash index
    CMD_DIR_LAT,   // latch directory entry and fill
    CMD_APPEND,    // write record at fill slot
    CMD_DBL_RD,    // read directory entry at sweep index
    CMD_DBL_WR,    // write two copies
    CMD_SPL_INIT,  // set up split sweep
    CMD_SPL_DIR,   // rewrite one directory entry of span
    CMD_RI_RD,     // read record at sweep slot
    CMD_RI_DIR,    // read directory for that record
    CMD_RI_WR,     // write record to kept or new bucket
    CMD_LK_RD,     // read record for lookup
    CMD_LK_CHK,    // compare record, hold it when it matches
    CMD_INIT       // directory init sweep step
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic emit;
    logic [1:0] emit_status;
    logic emit_rec;
    logic emit_last;
    logic init_start;
  } ctl_t;

  typedef struct packed {
    logic        is_lookup;
    logic        bkt_room;
    logic        ld_ge_gd;
    logic        gd_max;
    logic        no_free;
    logic        dbl_done;
    logic        span_done;
    logic        ri_done;
    logic        lk_done;
    logic        lk_hit;
    logic        lk_any;
    logic        init_done;
  } sts_t;

  // directory index: low bits reversed, key bit 0 is the msb of index
  function automatic logic [DirW-1:0] dir_index(input logic [31:0] k,
                                                input logic [DepthW-1:0] d);
    logic [DirW-1:0] idx;
    idx = '0;
    for (int i = 0; i < DirW; i++) begin
      if (i < int'(d)) idx[int'(d) - 1 - i] = k[i];
    end
    return idx;
  endfunction

endpackage

FILE: hdl/extendible_hash_index_top.sv
// ----------------------------------------------------------------------------
// extendible_hash_index_top
// Extendible hash index with bucket split and directory doubling.
// ----------------------------------------------------------------------------
// Usage: present a transaction on in_item and raise start; it is taken at a
// clock edge where start is high and busy is low. Results appear on out_item
// for one cycle each with out_valid high; out_item.last marks the final one.
// Insert: one result; busy falls as it appears, so the next transaction can
// be taken at the edge ending it. A doubling reads and writes back each old
// directory entry; a split sets up, rewrites each directory entry of the span,
// then reads, looks up and rewrites each stored record; each then retries
// the insert from the hash step.
// Lookup: a read and a compare step per stored record of the bucket, then
// the final result.
// Reset and each write through cfg_we run a sweep of the directory and fill
// memories; busy stays high meanwhile.
// The receiver cannot stall: results are always taken.
// ----------------------------------------------------------------------------
module extendible_hash_index_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ehi_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output logic               out_valid,
  output ehi_pkg::out_item_t out_item
);
  import ehi_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ehi_ctrl u_ctrl (
    .clk, .rst_n, .start, .cfg_we, .sts, .ctl, .busy
  );

  ehi_datapath u_dp (
    .clk, .rst_n, .in_item, .cfg_we, .cfg_wdata, .ctl, .sts,
    .out_item, .out_valid
  );

endmodule

FILE: hdl/ehi_datapath.sv
// ----------------------------------------------------------------------------
// ehi_datapath
// Directory, bucket fills and record memories with sweep counters.
// ----------------------------------------------------------------------------
module ehi_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ehi_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  ehi_pkg::ctl_t     ctl,
  output ehi_pkg::sts_t     sts,
  output ehi_pkg::out_item_t out_item,
  output logic              out_valid
);
  import ehi_pkg::*;

  // memories
  logic [BktW-1:0]   dir_bkt_mem [DirSize];
  logic [DepthW-1:0] dir_ld_mem  [DirSize];
  logic [FillW-1:0]  fill_mem    [NumBuckets];
  logic [31:0]       key_mem     [NumBuckets*BucketCapacity];
  logic [31:0]       pay_mem     [NumBuckets*BucketCapacity];

  logic [DepthW-1:0] gd_r, init_d_r;
  logic [DepthW-1:0] cfg_d;
  logic [FreeW-1:0]  nfree_r;
  logic              op_r;
  logic [31:0]       key_r, pay_r;
  logic [DirW-1:0]   h_r;
  logic [BktW-1:0]   b_r, nb_r, tb_rd_r;
  logic [DepthW-1:0] ld_rd_r, ld_r;
  logic [FillW-1:0]  fill_r, keep_r, nfill_r;
  logic [DirW:0]     cnt_r;     // sweep counter (dir index or span)
  logic [DirW:0]     span_r;
  logic [DirW-1:0]   start_r;
  logic [FillW-1:0]  rcnt_r;
  logic [31:0]       rk_r, rp_r, mk_r, mp_r;
  logic [DirW-1:0]   rd_a;
  logic              any_r;
  logic [DirW:0]     dir_n;
  out_item_t         out_r;
  logic              out_v_r;

  assign dir_n = (DirW+1)'(1) << gd_r;

  // written depth clamped to 1..MaxDepth
  always_comb begin
    if (cfg_wdata == 4'd0)             cfg_d = DepthW'(1);
    else if (cfg_wdata > 4'(MaxDepth)) cfg_d = DepthW'(MaxDepth);
    else                               cfg_d = cfg_wdata;
  end

  // directory read address
  always_comb begin
    rd_a = h_r;
    unique case (ctl.cmd)
      CMD_DBL_RD: rd_a = cnt_r[DirW-1:0] - 1'b1;
      CMD_RI_DIR: rd_a = dir_index(rk_r, gd_r);
      default:    rd_a = h_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gd_r     <= DepthW'(1);
      init_d_r <= DepthW'(1);
      nfree_r  <= FreeW'(2);
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      out_v_r <= ctl.emit;
      if (cfg_we) init_d_r <= cfg_d;
      if (ctl.init_start) begin
        cnt_r   <= '0;
        nfree_r <= FreeW'(2);
        gd_r    <= cfg_d;
      end
      unique case (ctl.cmd)
        CMD_INIT:    cnt_r <= cnt_r + 1'b1;
        CMD_DIR_LAT: cnt_r <= dir_n;
        CMD_DBL_WR: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == (DirW+1)'(1)) gd_r <= gd_r + 1'b1;
        end
        CMD_SPL_INIT: begin
          cnt_r   <= '0;
          nfree_r <= nfree_r + 1'b1;
        end
        CMD_SPL_DIR: cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers and memory writes
  always_ff @(posedge clk) begin
    tb_rd_r   <= dir_bkt_mem[rd_a];
    ld_rd_r   <= dir_ld_mem[rd_a];
    unique case (ctl.cmd)
      CMD_LOAD: begin
        op_r  <= in_item.operation;
        key_r <= in_item.key;
        pay_r <= in_item.payload;
      end
      CMD_HASH:    h_r <= dir_index(key_r, gd_r);
      CMD_DIR_LAT: begin
        b_r <= tb_rd_r; ld_r <= ld_rd_r; fill_r <= fill_mem[tb_rd_r];
        rcnt_r <= '0; any_r <= 1'b0;
      end
      CMD_APPEND: begin
        key_mem[{b_r, fill_r[SlotW-1:0]}] <= key_r;
        pay_mem[{b_r, fill_r[SlotW-1:0]}] <= pay_r;
        fill_mem[b_r] <= fill_r + 1'b1;
      end
      CMD_DBL_WR: begin
        dir_bkt_mem[{cnt_r[DirW-2:0] - 1'b1, 1'b0}] <= tb_rd_r;
        dir_bkt_mem[{cnt_r[DirW-2:0] - 1'b1, 1'b1}] <= tb_rd_r;
        dir_ld_mem[{cnt_r[DirW-2:0] - 1'b1, 1'b0}]  <= ld_rd_r;
        dir_ld_mem[{cnt_r[DirW-2:0] - 1'b1, 1'b1}]  <= ld_rd_r;
      end
      CMD_SPL_INIT: begin
        span_r  <= (DirW+1)'(1) << (gd_r - ld_r);
        start_r <= h_r & ~DirW'(((DirW+1)'(1) << (gd_r - ld_r)) - 1'b1);
        nb_r    <= nfree_r[BktW-1:0];
        keep_r  <= '0;
        nfill_r <= '0;
        rcnt_r  <= '0;
      end
      CMD_SPL_DIR: begin
        dir_ld_mem[start_r + cnt_r[DirW-1:0]] <= ld_r + 1'b1;
        if (cnt_r >= (span_r >> 1))
          dir_bkt_mem[start_r + cnt_r[DirW-1:0]] <= nb_r;
      end
      CMD_RI_RD: begin
        rk_r <= key_mem[{b_r, rcnt_r[SlotW-1:0]}];
        rp_r <= pay_mem[{b_r, rcnt_r[SlotW-1:0]}];
      end
      CMD_RI_WR: begin
        rcnt_r <= rcnt_r + 1'b1;
        if (tb_rd_r == b_r) begin
          key_mem[{b_r, keep_r[SlotW-1:0]}] <= rk_r;
          pay_mem[{b_r, keep_r[SlotW-1:0]}] <= rp_r;
          keep_r <= keep_r + 1'b1;
          fill_mem[b_r] <= keep_r + 1'b1;
          fill_mem[nb_r] <= nfill_r;
        end else begin
          key_mem[{nb_r, nfill_r[SlotW-1:0]}] <= rk_r;
          pay_mem[{nb_r, nfill_r[SlotW-1:0]}] <= rp_r;
          nfill_r <= nfill_r + 1'b1;
          fill_mem[nb_r] <= nfill_r + 1'b1;
          fill_mem[b_r] <= keep_r;
        end
      end
      CMD_LK_RD: begin
        rcnt_r <= rcnt_r + 1'b1;
        rk_r   <= key_mem[{b_r, rcnt_r[SlotW-1:0]}];
        rp_r   <= pay_mem[{b_r, rcnt_r[SlotW-1:0]}];
      end
      // hold the newest match until the next one or the end of the bucket
      CMD_LK_CHK: begin
        if (rk_r == key_r) begin
          mk_r  <= rk_r;
          mp_r  <= rp_r;
          any_r <= 1'b1;
        end
      end
      CMD_INIT: begin
        dir_ld_mem[cnt_r[DirW-1:0]]  <= DepthW'(1);
        dir_bkt_mem[cnt_r[DirW-1:0]] <=
          (cnt_r < (((DirW+1)'(1) << init_d_r) >> 1)) ? BktW'(0) : BktW'(1);
        fill_mem[cnt_r[DirW-1:0]] <= '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_r.status        <= ctl.emit_status;
      out_r.found_key     <= ctl.emit_rec ? mk_r : 32'd0;
      out_r.found_payload <= ctl.emit_rec ? mp_r : 32'd0;
      out_r.last          <= ctl.emit_last;
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_v_r;

  // status to controller
  always_comb begin
    sts.is_lookup = op_r;
    sts.bkt_room  = fill_r < FillW'(BucketCapacity);
    sts.ld_ge_gd  = ld_r >= gd_r;
    sts.gd_max    = gd_r >= DepthW'(MaxDepth);
    sts.no_free   = nfree_r >= FreeW'(NumBuckets);
    sts.dbl_done  = cnt_r == (DirW+1)'(1);
    sts.span_done = cnt_r == span_r - 1'b1;
    sts.ri_done   = rcnt_r == fill_r - 1'b1;
    sts.lk_done   = rcnt_r >= fill_r;
    sts.lk_hit    = rk_r == key_r;
    sts.lk_any    = any_r;
    sts.init_done = cnt_r == (DirW+1)'(DirSize - 1);
  end

endmodule

FILE: hdl/ehi_ctrl.sv
// ----------------------------------------------------------------------------
// ehi_ctrl
// Sequencer for insert, lookup, doubling, splitting and init sweeps.
// ----------------------------------------------------------------------------
module ehi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          cfg_we,
  input  ehi_pkg::sts_t sts,
  output ehi_pkg::ctl_t ctl,
  output logic          busy
);
  import ehi_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_HASH, S_DRD, S_DLAT, S_DEC, S_DBL_RD, S_DBL_WR,
    S_SPL_INIT, S_SPL_DIR, S_RI_RD, S_RI_DIR, S_RI_WAIT, S_RI_WR,
    S_LK_RD, S_LK_CHK, S_LK_END
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.cmd = CMD_NONE;
    unique case (state_r)
      S_INIT: begin
        ctl.cmd = CMD_INIT;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin ctl.cmd = CMD_LOAD; state_nxt = S_HASH; end
      S_HASH: begin ctl.cmd = CMD_HASH; state_nxt = S_DRD; end
      S_DRD:  begin ctl.cmd = CMD_DIR_RD; state_nxt = S_DLAT; end
      S_DLAT: begin ctl.cmd = CMD_DIR_LAT; state_nxt = S_DEC; end
      S_DEC: begin
        if (sts.is_lookup) state_nxt = S_LK_RD;
        else if (sts.bkt_room) begin
          ctl.cmd = CMD_APPEND; ctl.emit = 1'b1;
          ctl.emit_status = ST_INSERTED; ctl.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.ld_ge_gd) begin
          if (sts.gd_max) begin
            ctl.emit = 1'b1; ctl.emit_status = ST_FULL; ctl.emit_last = 1'b1;
            state_nxt = S_IDLE;
          end else state_nxt = S_DBL_RD;
        end else if (sts.no_free) begin
          ctl.emit = 1'b1; ctl.emit_status = ST_FULL; ctl.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else state_nxt = S_SPL_INIT;
      end
      S_DBL_RD: begin ctl.cmd = CMD_DBL_RD; state_nxt = S_DBL_WR; end
      S_DBL_WR: begin
        ctl.cmd = CMD_DBL_WR;
        state_nxt = (sts.dbl_done) ? S_HASH : S_DBL_RD;
      end
      S_SPL_INIT: begin ctl.cmd = CMD_SPL_INIT; state_nxt = S_SPL_DIR; end
      S_SPL_DIR: begin
        ctl.cmd = CMD_SPL_DIR;
        if (sts.span_done) state_nxt = S_RI_RD;
      end
      S_RI_RD:   begin ctl.cmd = CMD_RI_RD; state_nxt = S_RI_DIR; end
      S_RI_DIR:  begin ctl.cmd = CMD_RI_DIR; state_nxt = S_RI_WAIT; end
      // keep the directory read address on the record's index
      S_RI_WAIT: begin ctl.cmd = CMD_RI_DIR; state_nxt = S_RI_WR; end
      S_RI_WR: begin
        ctl.cmd = CMD_RI_WR;
        state_nxt = sts.ri_done ? S_HASH : S_RI_RD;
      end
      S_LK_RD: begin
        if (sts.lk_done) state_nxt = S_LK_END;
        else begin ctl.cmd = CMD_LK_RD; state_nxt = S_LK_CHK; end
      end
      // a new match releases the one held before it
      S_LK_CHK: begin
        ctl.cmd = CMD_LK_CHK;
        if (sts.lk_hit && sts.lk_any) begin
          ctl.emit = 1'b1; ctl.emit_status = ST_MATCH; ctl.emit_rec = 1'b1;
        end
        state_nxt = S_LK_RD;
      end
      // held match goes out as the final result, else no match
      S_LK_END: begin
        ctl.emit = 1'b1; ctl.emit_last = 1'b1;
        if (sts.lk_any) begin
          ctl.emit_status = ST_MATCH; ctl.emit_rec = 1'b1;
        end else begin
          ctl.emit_status = ST_NOMATCH;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      ctl.init_start = 1'b1;
      state_nxt = S_INIT;
    end
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule
